// File: design/swrm_pkg.sv
`timescale 1ns / 1ps
// swrm_pkg: field widths, constants and the sample record shared by the
// sliding window rate meter modules. No dependencies.

package swrm_pkg;

	localparam int TIME_W     = 40;
	localparam int BYTES_W    = 48;
	localparam int TOTAL_W    = 49;
	localparam int RECV_W     = 49;
	localparam int SIZE_W     = 50;
	localparam int RATE_W     = 31;
	localparam int RESUME_W   = 48;
	localparam int WIN_W      = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;

	// bytes * 1000 fits in 58 bits
	localparam int PROD_W     = 58;
	localparam int MS_PER_S   = 1000;
	localparam int WINDOW_RESET = 5000;

	localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RESUME   = 2'd0,
		REG_WINDOW   = 2'd1,
		REG_SUPPRESS = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [TIME_W-1:0]  stamp;
		logic [BYTES_W-1:0] bytes;
	} sample_t;

endpackage

// File: design/swrm_ring.sv
`timescale 1ns / 1ps
// swrm_ring: sample memory, one write port and one read port with a
// registered read. Depends on swrm_pkg.

module swrm_ring import swrm_pkg::*; #(
	parameter int DEPTH = 64,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  sample_t          wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output sample_t          rdata
);

	sample_t mem [DEPTH];
	sample_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/swrm_div.sv
`timescale 1ns / 1ps
// swrm_div: restoring divider, one quotient bit per cycle, with the
// quotient saturated to the rate width and zero for a zero divisor.
// Depends on swrm_pkg.

module swrm_div import swrm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [PROD_W-1:0]  dividend,
	input  logic [TIME_W-1:0]  divisor,
	output logic               done,
	output logic [RATE_W-1:0]  quotient
);

	localparam int DSH_W = TIME_W + RATE_W;
	localparam int CNT_W = $clog2(RATE_W);

	typedef enum logic [2:0] {
		D_IDLE  = 3'b001,
		D_CHECK = 3'b010,
		D_RUN   = 3'b100
	} div_state_t;

	div_state_t          state_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [PROD_W-1:0]   rem_q;
	logic [DSH_W-1:0]    dsh_q;
	logic [RATE_W-1:0]   quo_q;
	logic                fits;

	assign fits = DSH_W'(rem_q) >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_CHECK;
					end
				end
				D_CHECK: begin
					if (dsh_q == '0 || fits) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						cnt_q   <= CNT_W'(RATE_W - 1);
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			D_IDLE: begin
				if (start) begin
					rem_q <= dividend;
					dsh_q <= DSH_W'(divisor) << RATE_W;
				end
			end
			D_CHECK: begin
				if (dsh_q == '0) begin
					quo_q <= '0;
				end else if (fits) begin
					quo_q <= RATE_MAX;
				end else begin
					quo_q <= '0;
					dsh_q <= dsh_q >> 1;
				end
			end
			D_RUN: begin
				if (fits) begin
					rem_q <= rem_q - dsh_q[PROD_W-1:0];
				end
				quo_q <= {quo_q[RATE_W-2:0], fits};
				dsh_q <= dsh_q >> 1;
			end
			default: ;
		endcase
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: design/sliding_window_rate_meter_core.sv
`timescale 1ns / 1ps
// sliding_window_rate_meter_core: windowed byte rate over a ring of samples.
// Each accepted transaction appends a sample, evicts stale samples (each by a
// read and a check state), multiplies and divides; a zero divisor or saturated
// rate skips the 31 divider steps. A suppressed transaction is dropped. Input
// stalls until the result is loaded. Reset clears state, pointers, configuration
// and output valid only. Depends on swrm_pkg, swrm_ring and swrm_div.

module sliding_window_rate_meter_core import swrm_pkg::*; #(
	parameter int SAMPLE_DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [TIME_W-1:0]          now_ms,
	input  logic [BYTES_W-1:0]         bytes_received,
	input  logic signed [TOTAL_W-1:0]  bytes_total,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [RECV_W-1:0]          total_received,
	output logic signed [SIZE_W-1:0]   total_size,
	output logic [RATE_W-1:0]          rate_bps
);

	localparam int IDX_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(SAMPLE_DEPTH + 1);
	localparam int SUM_W = IDX_W + 1;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_APPEND = 8'b0000_0010,
		S_READ   = 8'b0000_0100,
		S_CHECK  = 8'b0000_1000,
		S_MUL    = 8'b0001_0000,
		S_START  = 8'b0010_0000,
		S_DIV    = 8'b0100_0000,
		S_OUT    = 8'b1000_0000
	} state_t;

	state_t                     state_q;
	logic [RESUME_W-1:0]        resume_q;
	logic [WIN_W-1:0]           window_q;
	logic                       suppress_q;

	logic [IDX_W-1:0]           oldest_q;
	logic [CNT_W-1:0]           count_q;

	logic [TIME_W-1:0]          now_q;
	logic [BYTES_W-1:0]         bytes_q;
	logic [TOTAL_W-1:0]         total_q;
	logic [BYTES_W-1:0]         num_q;
	logic [TIME_W-1:0]          den_q;
	logic [PROD_W-1:0]          prod_s1;

	logic                       out_valid_q;
	logic [RECV_W-1:0]          recv_q;
	logic [SIZE_W-1:0]          size_q;
	logic [RATE_W-1:0]          rate_q;

	logic                       in_take;
	logic                       full;
	logic [SUM_W-1:0]           slot_sum;
	logic [IDX_W-1:0]           slot;
	logic [IDX_W-1:0]           oldest_next;
	logic                       stale;
	logic                       out_load;
	sample_t                    rd_sample;
	sample_t                    wr_sample;
	logic                       div_done;
	logic [RATE_W-1:0]          div_quo;

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;

	assign full        = (count_q == CNT_W'(SAMPLE_DEPTH));
	assign slot_sum    = SUM_W'(oldest_q) + SUM_W'(count_q);
	assign slot        = (slot_sum >= SUM_W'(SAMPLE_DEPTH)) ?
	                     IDX_W'(slot_sum - SUM_W'(SAMPLE_DEPTH)) : IDX_W'(slot_sum);
	assign oldest_next = (oldest_q == IDX_W'(SAMPLE_DEPTH - 1)) ? '0 : oldest_q + 1'b1;

	assign stale = ((TIME_W + 1)'(rd_sample.stamp) + (TIME_W + 1)'(window_q))
	               < (TIME_W + 1)'(now_q);

	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	assign wr_sample.stamp = now_q;
	assign wr_sample.bytes = bytes_q;

	swrm_ring #(
		.DEPTH (SAMPLE_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (state_q == S_APPEND),
		.waddr (full ? oldest_q : slot),
		.wdata (wr_sample),
		.re    (state_q == S_READ),
		.raddr (oldest_q),
		.rdata (rd_sample)
	);

	swrm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_START),
		.dividend (prod_s1),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resume_q   <= '0;
			window_q   <= WIN_W'(WINDOW_RESET);
			suppress_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RESUME:   resume_q   <= cfg_data[RESUME_W-1:0];
				REG_WINDOW:   window_q   <= cfg_data[WIN_W-1:0];
				REG_SUPPRESS: suppress_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			oldest_q <= '0;
			count_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_take && !suppress_q) begin
						state_q <= S_APPEND;
					end
				end
				S_APPEND: begin
					if (full) begin
						oldest_q <= oldest_next;
					end else begin
						count_q <= count_q + 1'b1;
					end
					state_q <= S_READ;
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					if (stale && count_q > CNT_W'(1)) begin
						oldest_q <= oldest_next;
						count_q  <= count_q - 1'b1;
						state_q  <= S_READ;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL:   state_q <= S_START;
				S_START: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// transaction payload and rate operands
	always_ff @(posedge clk) begin
		if (in_take) begin
			now_q   <= now_ms;
			bytes_q <= bytes_received;
			total_q <= bytes_total;
		end
		if (state_q == S_CHECK) begin
			if (count_q == CNT_W'(1)) begin
				num_q <= bytes_q;
				den_q <= now_q;
			end else if (now_q > rd_sample.stamp && bytes_q >= rd_sample.bytes) begin
				num_q <= bytes_q - rd_sample.bytes;
				den_q <= now_q - rd_sample.stamp;
			end else begin
				num_q <= '0;
				den_q <= '0;
			end
		end
		if (state_q == S_MUL) begin
			prod_s1 <= PROD_W'(num_q) * PROD_W'(MS_PER_S);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			recv_q <= RECV_W'(resume_q) + RECV_W'(bytes_q);
			size_q <= SIZE_W'(resume_q) + {total_q[TOTAL_W-1], total_q};
			rate_q <= div_quo;
		end
	end

	assign out_valid      = out_valid_q;
	assign total_received = recv_q;
	assign total_size     = size_q;
	assign rate_bps       = rate_q;

endmodule
